// ===== design/kpc_pkg.sv =====
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types and constants for the key press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package kpc_pkg;

  // Register widths
  localparam int unsigned DebW    = 8;
  localparam int unsigned LongW   = 10;
  localparam int unsigned IdleW   = 16;
  localparam int unsigned HoldW   = 10;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;
  // Phase counter: a stored count stays below the largest 10-bit limit
  localparam int unsigned PhCntW  = 10;

  // Register reset values
  localparam logic [DebW-1:0]  DebReset  = 8'd8;
  localparam logic [LongW-1:0] LongReset = 10'd100;
  localparam logic [IdleW-1:0] IdleReset = 16'd500;
  localparam logic [HoldW-1:0] HoldReset = 10'd150;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_LONG_PRESS   = 2'd1,
    REG_SLEEP_TICKS  = 2'd2,
    REG_HOLDOFF      = 2'd3
  } cfg_reg_t;

  // Event codes
  typedef enum logic [1:0] {
    EV_SHORT = 2'd0,
    EV_LONG  = 2'd1,
    EV_SLEEP = 2'd2,
    EV_READY = 2'd3
  } event_code_t;

  // Classifier phases
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_DEB_PRESS = 3'd1,
    PH_HOLD      = 3'd2,
    PH_HOLDOFF   = 3'd3,
    PH_WAIT_REL  = 3'd4,
    PH_DEB_REL   = 3'd5
  } phase_t;

  // Register file contents handed to the core
  typedef struct packed {
    logic [DebW-1:0]  debounce;
    logic [LongW-1:0] long_press;
    logic [IdleW-1:0] sleep_ticks;
    logic [HoldW-1:0] holdoff;
  } cfg_t;

  // One classified event from the core
  typedef struct packed {
    logic        fire;
    event_code_t code;
    logic        mode;
  } event_t;

endpackage

`default_nettype wire

// ===== design/kpc_tick_if.sv =====
// ----------------------------------------------------------------------------
// kpc_tick_if
// Tick channel: one item per tick, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpc_tick_if;
  logic valid;
  logic ready;
  logic key_released;
  logic edge_seen;

  modport source (output valid, key_released, edge_seen, input ready);
  modport sink   (input valid, key_released, edge_seen, output ready);
endinterface

`default_nettype wire

// ===== design/kpc_event_if.sv =====
// ----------------------------------------------------------------------------
// kpc_event_if
// Event channel: classified key events, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpc_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic       mode_now;

  modport source (output valid, event_code, mode_now, input ready);
  modport sink   (input valid, event_code, mode_now, output ready);
endinterface

`default_nettype wire

// ===== design/kpc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// kpc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kpc_pkg::CfgIdxW-1:0]   index;
  logic [kpc_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/kpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kpc_cfg_regs
// Configuration register file; always ready, data truncated to field width.
// ----------------------------------------------------------------------------
`default_nettype none

module kpc_cfg_regs (
  input  wire logic     clk,
  input  wire logic     rst,
  kpc_cfg_if.sink       cfg,
  output kpc_pkg::cfg_t regs
);

  kpc_pkg::cfg_t regs_q;
  kpc_pkg::cfg_reg_t idx;

  assign cfg.ready = 1'b1;
  assign idx       = kpc_pkg::cfg_reg_t'(cfg.index);
  assign regs      = regs_q;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.debounce     <= kpc_pkg::DebReset;
      regs_q.long_press   <= kpc_pkg::LongReset;
      regs_q.sleep_ticks  <= kpc_pkg::IdleReset;
      regs_q.holdoff      <= kpc_pkg::HoldReset;
    end else if (cfg.valid) begin
      case (idx)
        kpc_pkg::REG_DEBOUNCE:     regs_q.debounce     <= cfg.data[kpc_pkg::DebW-1:0];
        kpc_pkg::REG_LONG_PRESS:   regs_q.long_press   <= cfg.data[kpc_pkg::LongW-1:0];
        kpc_pkg::REG_SLEEP_TICKS:  regs_q.sleep_ticks  <= cfg.data[kpc_pkg::IdleW-1:0];
        kpc_pkg::REG_HOLDOFF:      regs_q.holdoff      <= cfg.data[kpc_pkg::HoldW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/kpc_core.sv =====
// ----------------------------------------------------------------------------
// kpc_core
// Press classifier state machine; advances one tick when step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module kpc_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic       key_released,
  input  wire logic       edge_seen,
  input  kpc_pkg::cfg_t   regs,
  output kpc_pkg::event_t ev
);

  kpc_pkg::phase_t             phase, phase_next;
  logic [kpc_pkg::PhCntW-1:0]  phase_count, phase_count_next;
  logic [kpc_pkg::IdleW-1:0]   idle_count, idle_count_next;
  logic                        armed, armed_next;
  logic                        mode, mode_next;

  logic [kpc_pkg::PhCntW-1:0]  cnt_inc;
  logic [kpc_pkg::IdleW-1:0]   idle_inc;
  logic [kpc_pkg::PhCntW-1:0]  deb_lim;
  logic [kpc_pkg::PhCntW-1:0]  long_lim;
  logic [kpc_pkg::PhCntW-1:0]  hold_lim;

  assign cnt_inc  = phase_count + kpc_pkg::PhCntW'(1);
  assign idle_inc = idle_count + kpc_pkg::IdleW'(1);
  assign deb_lim  = kpc_pkg::PhCntW'(regs.debounce);
  assign long_lim = kpc_pkg::PhCntW'(regs.long_press);
  assign hold_lim = kpc_pkg::PhCntW'(regs.holdoff);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= kpc_pkg::PH_IDLE;
      phase_count <= '0;
      idle_count  <= '0;
      armed       <= 1'b1;
      mode        <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      phase_count <= phase_count_next;
      idle_count  <= idle_count_next;
      armed       <= armed_next;
      mode        <= mode_next;
    end
  end

  // Next state and event
  always_comb begin
    phase_next       = phase;
    phase_count_next = phase_count;
    idle_count_next  = idle_count;
    armed_next       = armed;
    mode_next        = mode;
    ev.fire          = 1'b0;
    ev.code          = kpc_pkg::EV_SHORT;

    case (phase)
      kpc_pkg::PH_DEB_PRESS: begin
        phase_count_next = cnt_inc;
        if (cnt_inc >= deb_lim) begin
          phase_count_next = '0;
          if (key_released) begin
            armed_next = 1'b1;
            phase_next = kpc_pkg::PH_IDLE;
          end else begin
            phase_next = kpc_pkg::PH_HOLD;
          end
        end
      end
      kpc_pkg::PH_HOLD: begin
        phase_count_next = cnt_inc;
        if (key_released) begin
          phase_next       = kpc_pkg::PH_DEB_REL;
          phase_count_next = '0;
          ev.fire          = 1'b1;
          ev.code          = kpc_pkg::EV_SHORT;
        end else if (cnt_inc >= long_lim) begin
          mode_next        = ~mode;
          phase_next       = (hold_lim == '0) ? kpc_pkg::PH_WAIT_REL : kpc_pkg::PH_HOLDOFF;
          phase_count_next = '0;
          ev.fire          = 1'b1;
          ev.code          = kpc_pkg::EV_LONG;
        end
      end
      kpc_pkg::PH_HOLDOFF: begin
        phase_count_next = cnt_inc;
        if (cnt_inc >= hold_lim) begin
          phase_next       = kpc_pkg::PH_WAIT_REL;
          phase_count_next = '0;
        end
      end
      kpc_pkg::PH_WAIT_REL: begin
        if (key_released) begin
          phase_next       = kpc_pkg::PH_DEB_REL;
          phase_count_next = '0;
        end
      end
      kpc_pkg::PH_DEB_REL: begin
        phase_count_next = cnt_inc;
        if (cnt_inc >= deb_lim) begin
          armed_next       = 1'b1;
          phase_next       = kpc_pkg::PH_IDLE;
          phase_count_next = '0;
          ev.fire          = 1'b1;
          ev.code          = kpc_pkg::EV_READY;
        end
      end
      default: begin
        // Idle, and any unused code
        phase_next = kpc_pkg::PH_IDLE;
        if (edge_seen && armed) begin
          armed_next       = 1'b0;
          idle_count_next  = '0;
          phase_next       = kpc_pkg::PH_DEB_PRESS;
          phase_count_next = '0;
        end else if (idle_inc >= regs.sleep_ticks) begin
          idle_count_next = '0;
          ev.fire         = 1'b1;
          ev.code         = kpc_pkg::EV_SLEEP;
        end else begin
          idle_count_next = idle_inc;
        end
      end
    endcase

    ev.mode = mode_next;
  end

endmodule

`default_nettype wire

// ===== design/key_press_classifier_top.sv =====
// ----------------------------------------------------------------------------
// key_press_classifier_top
// Push-button press classifier: short, long, sleep and ready events.
// ----------------------------------------------------------------------------
// Takes one tick item per clock cycle unless a stalled event holds it back.
// An accepted tick sits in an input register while the classifier state
// machine decides its outcome; when the tick moves on, any event it raises
// is registered in the result register and transfers from there. With the
// event side ready, ticks flow back to back. While an event waits on the
// output, one more tick is still taken into the input register and the tick
// side then stalls until the event transfers. Register writes are taken
// every cycle and belong in gaps with no tick in flight.
`default_nettype none

module key_press_classifier_top (
  input  wire logic   clk,
  input  wire logic   rst,
  kpc_tick_if.sink    tick,
  kpc_event_if.source evt,
  kpc_cfg_if.sink     cfg
);

  kpc_pkg::cfg_t   regs;
  kpc_pkg::event_t ev;

  logic s1_valid;
  logic s1_released;
  logic s1_edge;
  logic s1_go;

  logic                 out_valid;
  kpc_pkg::event_code_t out_code;
  logic                 out_mode;

  // Input stage moves on when the result slot is free or draining
  assign s1_go      = s1_valid && (!out_valid || evt.ready);
  assign tick.ready = !s1_valid || s1_go;

  assign evt.valid      = out_valid;
  assign evt.event_code = out_code;
  assign evt.mode_now   = out_mode;

  kpc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  kpc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_go),
    .key_released (s1_released),
    .edge_seen    (s1_edge),
    .regs         (regs),
    .ev           (ev)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_released <= tick.key_released;
      s1_edge     <= tick.edge_seen;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= ev.fire;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && ev.fire) begin
      out_code <= ev.code;
      out_mode <= ev.mode;
    end
  end

endmodule

`default_nettype wire

// ===== design/kpc_checker.sv =====
// ----------------------------------------------------------------------------
// kpc_checker
// Port-level checks on the classifier's event stream.
// ----------------------------------------------------------------------------
`default_nettype none

module kpc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       evt_valid,
  input wire logic       evt_ready,
  input wire logic [1:0] evt_code,
  input wire logic       evt_mode
);

  logic seen;
  logic last_mode;
  logic evt_xfer;

  assign evt_xfer = evt_valid && evt_ready;

  // Mode of the last delivered event
  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      last_mode <= 1'b0;
    end else if (evt_xfer) begin
      seen      <= 1'b1;
      last_mode <= evt_mode;
    end
  end

  // No event straight out of reset
  a_no_event_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !evt_valid)
    else $error("event valid straight after reset");

  // A stalled event holds
  a_event_holds: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid && $stable(evt_code) && $stable(evt_mode))
    else $error("stalled event changed");

  // Only a long press changes the mode
  a_mode_steady: assert property (@(posedge clk) disable iff (rst)
    evt_xfer && seen && (evt_code != kpc_pkg::EV_LONG) |-> evt_mode == last_mode)
    else $error("mode changed without a long press");

  // A long press always toggles the mode
  a_mode_toggles: assert property (@(posedge clk) disable iff (rst)
    evt_xfer && seen && (evt_code == kpc_pkg::EV_LONG) |-> evt_mode != last_mode)
    else $error("long press did not toggle mode");

endmodule

bind key_press_classifier_top kpc_checker u_kpc_checker (
  .clk       (clk),
  .rst       (rst),
  .evt_valid (evt.valid),
  .evt_ready (evt.ready),
  .evt_code  (evt.event_code),
  .evt_mode  (evt.mode_now)
);

`default_nettype wire

// ===== dv/key_press_classifier_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_press_classifier_top_tb
// Self-checking bench for the key press classifier: ticks in, events out.
// ----------------------------------------------------------------------------
// A behavioural classifier runs alongside the block. Every tick transfer is
// fed to it, and the events it predicts are queued and compared, field by
// field, with each event transfer. The run covers the reset settings, a
// directed table, and phases of register settings (zero, minimum, wide
// writes with masking, random) filled with press sequences and random noise.
// The tick sender idles in bursts and the event receiver stalls on its own
// pattern.

module key_press_classifier_top_tb;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseTicks   = 40;

  // Predicted event
  typedef struct packed {
    kpc_pkg::event_code_t code;
    logic                 mode;
  } key_event_t;

  // Directed stimulus row; typed rows carry a hand-worked event
  typedef struct packed {
    logic                 rel;
    logic                 edg;
    logic                 typed;
    logic                 fire;
    kpc_pkg::event_code_t code;
    logic                 mode;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kpc_tick_if  tick_ch ();
  kpc_event_if evt_ch ();
  kpc_cfg_if   cfg_ch ();

  key_press_classifier_top dut (
    .clk (clk),
    .rst (rst),
    .tick(tick_ch),
    .evt (evt_ch),
    .cfg (cfg_ch)
  );

  always #4 clk = ~clk;

  // Classifier copy: registers and state
  logic [7:0]       deb_lim;
  logic [9:0]       long_lim;
  logic [15:0]      idle_lim;
  logic [9:0]       hold_lim;
  kpc_pkg::phase_t  press_phase;
  logic [15:0]      phase_ticks;
  logic [15:0]      idle_ticks;
  logic             armed;
  logic             mode;

  key_event_t  pending_events [$];
  key_event_t  due_event;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_style = 0;

  // Hand-worked table, registers: debounce 1, long 2, idle 3, hold-off 1.
  // Mode is 1 on entry (left by the reset-value long press).
  tick_row_t dir_rows [21] = '{
    '{1'b1, 1'b0, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},  // idle tick
    '{1'b0, 1'b1, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},  // press edge
    '{1'b0, 1'b1, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},  // edge in debounce, dropped
    '{1'b0, 1'b0, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b1, kpc_pkg::EV_LONG,  1'b0},  // long press, mode back to 0
    '{1'b0, 1'b1, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},  // hold-off ends
    '{1'b0, 1'b0, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},  // still held
    '{1'b1, 1'b0, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},  // release
    '{1'b1, 1'b1, 1'b1, 1'b1, kpc_pkg::EV_READY, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},  // press edge
    '{1'b1, 1'b0, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},  // bounce: released after debounce
    '{1'b1, 1'b0, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b1, kpc_pkg::EV_SLEEP, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},  // press edge
    '{1'b0, 1'b0, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b1, kpc_pkg::EV_SHORT, 1'b0},  // short press
    '{1'b0, 1'b1, 1'b1, 1'b1, kpc_pkg::EV_READY, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0, kpc_pkg::EV_SHORT, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b1, kpc_pkg::EV_SLEEP, 1'b0}
  };

  // One line per mismatch
  task automatic flag_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Advance the classifier by one tick; returns 1 when an event is due
  function automatic bit classify_tick(input logic rel, input logic edg,
                                       output key_event_t ev);
    bit fired;
    fired = 1'b0;
    ev    = '0;
    case (press_phase)
      kpc_pkg::PH_DEB_PRESS: begin
        phase_ticks = phase_ticks + 16'd1;
        if (phase_ticks >= deb_lim) begin
          if (rel) begin
            armed       = 1'b1;
            press_phase = kpc_pkg::PH_IDLE;
          end else begin
            press_phase = kpc_pkg::PH_HOLD;
          end
          phase_ticks = '0;
        end
      end
      kpc_pkg::PH_HOLD: begin
        phase_ticks = phase_ticks + 16'd1;
        if (rel) begin
          press_phase = kpc_pkg::PH_DEB_REL;
          phase_ticks = '0;
          fired       = 1'b1;
          ev.code     = kpc_pkg::EV_SHORT;
        end else if (phase_ticks >= long_lim) begin
          mode        = ~mode;
          press_phase = (hold_lim == '0) ? kpc_pkg::PH_WAIT_REL : kpc_pkg::PH_HOLDOFF;
          phase_ticks = '0;
          fired       = 1'b1;
          ev.code     = kpc_pkg::EV_LONG;
        end
      end
      kpc_pkg::PH_HOLDOFF: begin
        phase_ticks = phase_ticks + 16'd1;
        if (phase_ticks >= hold_lim) begin
          press_phase = kpc_pkg::PH_WAIT_REL;
          phase_ticks = '0;
        end
      end
      kpc_pkg::PH_WAIT_REL: begin
        if (rel) begin
          press_phase = kpc_pkg::PH_DEB_REL;
          phase_ticks = '0;
        end
      end
      kpc_pkg::PH_DEB_REL: begin
        phase_ticks = phase_ticks + 16'd1;
        if (phase_ticks >= deb_lim) begin
          armed       = 1'b1;
          press_phase = kpc_pkg::PH_IDLE;
          phase_ticks = '0;
          fired       = 1'b1;
          ev.code     = kpc_pkg::EV_READY;
        end
      end
      default: begin
        press_phase = kpc_pkg::PH_IDLE;
        if (edg && armed) begin
          armed       = 1'b0;
          idle_ticks  = '0;
          press_phase = kpc_pkg::PH_DEB_PRESS;
          phase_ticks = '0;
        end else begin
          idle_ticks = idle_ticks + 16'd1;
          if (idle_ticks >= idle_lim) begin
            idle_ticks = '0;
            fired      = 1'b1;
            ev.code    = kpc_pkg::EV_SLEEP;
          end
        end
      end
    endcase
    ev.mode = mode;
    return fired;
  endfunction

  // Tick transfer with burst/gap pacing on the sender side
  task automatic send_tick(input logic rel, input logic edg);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 5);
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    @(negedge clk);
    tick_ch.valid        <= 1'b1;
    tick_ch.key_released <= rel;
    tick_ch.edge_seen    <= edg;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
    burst_left--;
    items_sent++;
  endtask

  // Tick transfer plus prediction
  task automatic feed(input logic rel, input logic edg);
    key_event_t ev;
    send_tick(rel, edg);
    if (classify_tick(rel, edg, ev)) pending_events.push_back(ev);
  endtask

  // Idle gap, press edge, hold, release; edges and bounces sprinkled in
  task automatic run_press(input int unsigned idle_n, input int unsigned hold_n,
                           input int unsigned rel_n, input bit bouncy);
    repeat (idle_n) feed(1'b1, 1'b0);
    feed(1'b0, 1'b1);
    repeat (hold_n) feed(bouncy && ($urandom_range(0, 7) == 0), $urandom_range(0, 3) == 0);
    repeat (rel_n) feed(1'b1, $urandom_range(0, 7) == 0);
  endtask

  // Quiet the tick side and wait for every predicted event to arrive
  task automatic settle();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input kpc_pkg::cfg_reg_t idx,
                           input logic [kpc_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    // Registers keep only their own width
    case (idx)
      kpc_pkg::REG_DEBOUNCE:    deb_lim  = val[kpc_pkg::DebW-1:0];
      kpc_pkg::REG_LONG_PRESS:  long_lim = val[kpc_pkg::LongW-1:0];
      kpc_pkg::REG_SLEEP_TICKS: idle_lim = val[kpc_pkg::IdleW-1:0];
      kpc_pkg::REG_HOLDOFF:     hold_lim = val[kpc_pkg::HoldW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] d, input logic [15:0] l,
                              input logic [15:0] i, input logic [15:0] h);
    write_reg(kpc_pkg::REG_DEBOUNCE, d);
    write_reg(kpc_pkg::REG_LONG_PRESS, l);
    write_reg(kpc_pkg::REG_SLEEP_TICKS, i);
    write_reg(kpc_pkg::REG_HOLDOFF, h);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Receiver stall pattern: always ready, coin toss, or mostly stalled
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_left  = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_style)
      0:       evt_ch.ready <= 1'b1;
      1:       evt_ch.ready <= 1'($urandom_range(0, 1));
      default: evt_ch.ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Event checker
  always @(posedge clk) begin
    if (!rst && evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1) begin
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("event %0d with nothing pending", evt_ch.event_code));
      end else begin
        due_event = pending_events.pop_front();
        if (evt_ch.event_code !== due_event.code)
          flag_mismatch($sformatf("event_code %0d, expected %0d",
                                  evt_ch.event_code, due_event.code));
        if (evt_ch.mode_now !== due_event.mode)
          flag_mismatch($sformatf("mode_now %0d, expected %0d",
                                  evt_ch.mode_now, due_event.mode));
      end
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("[key_press_classifier_top] ERROR");
    $finish;
  end

  // Main sequence
  initial begin
    key_event_t  ev;
    bit          fired;
    int unsigned start;
    int unsigned span;
    int unsigned idle_span;
    int unsigned pick;

    tick_ch.valid        = 1'b0;
    tick_ch.key_released = 1'b1;
    tick_ch.edge_seen    = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = kpc_pkg::REG_DEBOUNCE;
    cfg_ch.data          = '0;
    evt_ch.ready         = 1'b0;

    deb_lim     = kpc_pkg::DebReset;
    long_lim    = kpc_pkg::LongReset;
    idle_lim    = kpc_pkg::IdleReset;
    hold_lim    = kpc_pkg::HoldReset;
    press_phase = kpc_pkg::PH_IDLE;
    phase_ticks = '0;
    idle_ticks  = '0;
    armed       = 1'b1;
    mode        = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: one long press through hold-off, then a sleep
    run_press(3, 8 + 100 + 150 + 2, 12, 1'b0);
    repeat (505) feed(1'b1, 1'b0);

    // Directed table
    settle();
    program_regs(16'd1, 16'd2, 16'd3, 16'd1);
    foreach (dir_rows[r]) begin
      send_tick(dir_rows[r].rel, dir_rows[r].edg);
      fired = classify_tick(dir_rows[r].rel, dir_rows[r].edg, ev);
      if (dir_rows[r].typed) begin
        if (dir_rows[r].fire)
          pending_events.push_back(key_event_t'{code: dir_rows[r].code,
                                                mode: dir_rows[r].mode});
      end else if (fired) begin
        pending_events.push_back(ev);
      end
    end

    // Register phases
    for (int p = 0; p < 11; p++) begin
      settle();
      case (p)
        0: program_regs(16'd0, 16'd0, 16'd0, 16'd0);
        1: program_regs(16'd1, 16'd1, 16'd1, 16'd0);
        // Wide writes: upper bits dropped by the narrower registers
        2: program_regs(16'hFF03, 16'hFC06, 16'hFFFF, 16'hFC04);
        default: program_regs({8'($urandom), 8'($urandom_range(0, 6))},
                              {6'($urandom), 10'($urandom_range(0, 24))},
                              16'($urandom_range(0, 50)),
                              {6'($urandom), 10'($urandom_range(0, 12))});
      endcase

      start = items_sent;
      while (items_sent - start < PhaseTicks) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          repeat ($urandom_range(1, 8))
            feed(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          span      = deb_lim + long_lim + hold_lim + 6;
          idle_span = (idle_lim > 80) ? 80 : idle_lim + 2;
          run_press($urandom_range(0, idle_span), $urandom_range(0, span),
                    $urandom_range(0, deb_lim + 4), pick < 4);
        end
      end
    end

    // Drain and finish
    settle();
    if (pending_events.size() != 0)
      flag_mismatch($sformatf("%0d events never arrived", pending_events.size()));
    if (mismatch_count == 0) begin
      $display("[key_press_classifier_top] OK");
    end else begin
      $display("[key_press_classifier_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/kpc_pkg.sv
design/kpc_tick_if.sv
design/kpc_event_if.sv
design/kpc_cfg_if.sv
design/kpc_cfg_regs.sv
design/kpc_core.sv
design/key_press_classifier_top.sv
design/kpc_checker.sv
dv/key_press_classifier_top_tb.sv
